[hw/rtl/pltw_pkg.sv]
// ----------------------------------------------------------------------------
// pltw_pkg: shared types and constants of the page table walker
// Operation codes, sequencer states and entry field positions.
// ----------------------------------------------------------------------------
package pltw_pkg;

   localparam int INDEX_BITS  = 9;
   localparam int FRAME_LSB   = 12;
   localparam int VA_W        = 48;
   localparam int WIDX_W      = 14;
   localparam int WORD_W      = 64;
   localparam int ROOT_W      = 32;
   localparam int OP_W        = 2;

   // level index fields of the virtual address (low bit of each)
   localparam int L4_LSB      = 39;
   localparam int L3_LSB      = 30;
   localparam int L2_LSB      = 21;
   localparam int L1_LSB      = 12;

   localparam int BIT_PS      = 7;
   localparam int BIT_RW      = 1;

   localparam logic [WORD_W-1:0] FRAME_4K  = ~64'h0000_0000_0000_0FFF;
   localparam logic [WORD_W-1:0] FRAME_2M  = ~64'h0000_0000_001F_FFFF;
   localparam logic [WORD_W-1:0] OFFSET_4K = 64'h0000_0000_0000_0FFF;
   localparam logic [WORD_W-1:0] OFFSET_2M = 64'h0000_0000_001F_FFFF;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_XLATE = 2'd2,
      OP_ENWR  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DONE,
      S_RDATA,
      S_L4,
      S_L3,
      S_L2,
      S_L1
   } state_type;

endpackage

[hw/rtl/pltw_ram.sv]
// ----------------------------------------------------------------------------
// pltw_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pltw_ram #(
   parameter int WIDTH      = 64,
   parameter int DEPTH_LOG2 = 14
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [DEPTH_LOG2-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [DEPTH_LOG2-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [(1 << DEPTH_LOG2)];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/pltw_slot_unit.sv]
// ----------------------------------------------------------------------------
// pltw_slot_unit: table slot former
// Turns a table base and a 9-bit index into a store word slot and flags a
// table page that does not lie wholly inside the store.
// ----------------------------------------------------------------------------
module pltw_slot_unit
   import pltw_pkg::*;
#(
   parameter int STORE_WORDS_LOG2 = 14
) (
   input  logic [WORD_W-1:0]           base,
   input  logic [INDEX_BITS-1:0]       idx,
   output logic [STORE_WORDS_LOG2-1:0] slot,
   output logic                        fault
);

   localparam int TOP = STORE_WORDS_LOG2 - INDEX_BITS + FRAME_LSB;

   // any page number bit at or above the table page count is out of store
   assign fault = (base >> TOP) != '0;
   // low page number bits above the 9-bit index
   assign slot  = STORE_WORDS_LOG2'({base[WORD_W-1:FRAME_LSB], idx});

endmodule

[hw/rtl/four_level_page_table_walker.sv]
// ----------------------------------------------------------------------------
// four_level_page_table_walker: x86-64 style four-level page walk
// Local page-table store with word write/read, translate and enable-write.
// ----------------------------------------------------------------------------
// The block keeps 2^STORE_WORDS_LOG2 64-bit table words in one RAM with a
// registered read port. A write item does its work on acceptance and posts
// its result from S_DONE; a read item starts its RAM read on acceptance and
// posts the data from S_RDATA. Translate and enable-write walk the four
// levels with one RAM read per level, issued in S_IDLE, S_L4, S_L3 and S_L2;
// the result register is loaded in S_L1 (in S_L2 on a 2 MB mapping). A walk
// that hits a table page outside the store goes from the level that found it
// to S_DONE, which posts its fault. One item is in flight at a time:
// req_tready is high only while the sequencer is idle. A posted result stays
// in the output register while the next item is accepted; the sequencer
// waits at its last step only if that register is still full. The store has
// no reset: words must be written before a read or a walk touches them. The
// user must write root_table_address (csr_wr_en / csr_wr_data) only while the
// block is idle, which the block does not enforce; its bits 11..0 are ignored.
// ----------------------------------------------------------------------------
module four_level_page_table_walker
   import pltw_pkg::*;
#(
   parameter int STORE_WORDS_LOG2 = 14
) (
   input  logic          clock,
   input  logic          reset,
   // config
   input  logic          csr_wr_en,
   input  logic [31:0]   csr_wr_data,   // root_table_address
   // request
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,     // virtual_address[47:0], table_word_index[61:48],
                                        // write_data[125:62], zero[127:126]
   input  logic [1:0]    req_tuser,     // operation[1:0]
   // response
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata,     // physical_address[63:0], read_data[127:64]
   output logic [1:0]    rsp_tuser      // large_page[0], fault[1]
);

   localparam int AW     = STORE_WORDS_LOG2;
   localparam int WIDE_W = WIDX_W + STORE_WORDS_LOG2;

   // request fields
   logic [VA_W-1:0]   req_va;
   logic [WIDX_W-1:0] req_widx;
   logic [WORD_W-1:0] req_wdata;
   op_type            req_op;

   assign req_va    = req_tdata[VA_W-1:0];
   assign req_widx  = req_tdata[VA_W+WIDX_W-1:VA_W];
   assign req_wdata = req_tdata[VA_W+WIDX_W+WORD_W-1:VA_W+WIDX_W];
   assign req_op    = op_type'(req_tuser);

   // state
   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [VA_W-1:0]   va_ff, va_in;
   logic [AW-1:0]     slot_ff, slot_in;
   logic              fault_ff, fault_in;
   logic [ROOT_W-1:0] root_ff;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_pa_ff, rsp_pa_in;
   logic [WORD_W-1:0] rsp_rd_ff, rsp_rd_in;
   logic              rsp_large_ff, rsp_large_in;
   logic              rsp_fault_ff, rsp_fault_in;
   logic              rsp_load;
   logic              out_free;

   // RAM port
   logic              ram_wr_en, ram_rd_en;
   logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
   logic [WORD_W-1:0] ram_wr_data, ram_rd_data;

   // shared slot former
   logic [WORD_W-1:0]     unit_base;
   logic [INDEX_BITS-1:0] unit_idx;
   logic [AW-1:0]         unit_slot;
   logic                  unit_fault;

   // direct word index range check
   logic [WIDE_W-1:0] widx_wide;
   logic              widx_oor;
   logic              req_accept;

   assign widx_wide  = WIDE_W'(req_widx);
   assign widx_oor   = (widx_wide >> STORE_WORDS_LOG2) != '0;
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   pltw_ram #(
      .WIDTH      (WORD_W),
      .DEPTH_LOG2 (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pltw_slot_unit #(
      .STORE_WORDS_LOG2 (STORE_WORDS_LOG2)
   ) u_slot (
      .base  (unit_base),
      .idx   (unit_idx),
      .slot  (unit_slot),
      .fault (unit_fault)
   );

   // base comes from root at the start, then from the entry just read
   always_comb begin
      unit_base = ram_rd_data;
      unit_idx  = va_ff[L1_LSB +: INDEX_BITS];
      unique case (state_ff)
         S_IDLE: begin
            unit_base = WORD_W'(root_ff);
            unit_idx  = req_va[L4_LSB +: INDEX_BITS];
         end
         S_L4:    unit_idx = va_ff[L3_LSB +: INDEX_BITS];
         S_L3:    unit_idx = va_ff[L2_LSB +: INDEX_BITS];
         default: unit_idx = va_ff[L1_LSB +: INDEX_BITS];
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      va_in        = va_ff;
      slot_in      = slot_ff;
      fault_in     = fault_ff;
      req_tready   = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = slot_ff;
      ram_wr_data  = ram_rd_data | (WORD_W'(1) << BIT_RW);
      ram_rd_en    = 1'b0;
      ram_rd_addr  = unit_slot;
      rsp_load     = 1'b0;
      rsp_pa_in    = '0;
      rsp_rd_in    = '0;
      rsp_large_in = 1'b0;
      rsp_fault_in = 1'b0;

      unique case (state_ff) inside
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_accept) begin
               op_in    = req_op;
               va_in    = req_va;
               fault_in = 1'b0;
               unique case (req_op)
                  OP_WRITE: begin
                     ram_wr_en   = !widx_oor;
                     ram_wr_addr = widx_wide[AW-1:0];
                     ram_wr_data = req_wdata;
                     fault_in    = widx_oor;
                     state_in    = S_DONE;
                  end
                  OP_READ: begin
                     if (widx_oor) begin
                        fault_in = 1'b1;
                        state_in = S_DONE;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = widx_wide[AW-1:0];
                        state_in    = S_RDATA;
                     end
                  end
                  default: begin
                     if (unit_fault) begin
                        fault_in = 1'b1;
                        state_in = S_DONE;
                     end else begin
                        ram_rd_en = 1'b1;
                        slot_in   = unit_slot;
                        state_in  = S_L4;
                     end
                  end
               endcase
            end
         end

         S_DONE: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_fault_in = fault_ff;
               state_in     = S_IDLE;
            end
         end

         S_RDATA: begin
            if (out_free) begin
               rsp_load  = 1'b1;
               rsp_rd_in = ram_rd_data;
               state_in  = S_IDLE;
            end
         end

         S_L4, S_L3: begin
            if (unit_fault) begin
               fault_in = 1'b1;
               state_in = S_DONE;
            end else begin
               ram_rd_en = 1'b1;
               slot_in   = unit_slot;
               state_in  = (state_ff == S_L4) ? S_L3 : S_L2;
            end
         end

         S_L2: begin
            if (ram_rd_data[BIT_PS]) begin
               // 2 MB mapping: entry read here is final; held while output is full
               if (out_free) begin
                  rsp_load     = 1'b1;
                  rsp_large_in = 1'b1;
                  if (op_ff == OP_XLATE) begin
                     rsp_pa_in = (ram_rd_data & FRAME_2M) | (WORD_W'(va_ff) & OFFSET_2M);
                  end else begin
                     ram_wr_en = 1'b1;
                  end
                  state_in = S_IDLE;
               end
            end else if (unit_fault) begin
               fault_in = 1'b1;
               state_in = S_DONE;
            end else begin
               ram_rd_en = 1'b1;
               slot_in   = unit_slot;
               state_in  = S_L1;
            end
         end

         S_L1: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if (op_ff == OP_XLATE) begin
                  rsp_pa_in = (ram_rd_data & FRAME_4K) | (WORD_W'(va_ff) & OFFSET_4K);
               end else begin
                  ram_wr_en = 1'b1;
               end
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         root_ff      <= '0;
         fault_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fault_ff     <= fault_in;
         if (csr_wr_en) begin
            root_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      va_ff   <= va_in;
      slot_ff <= slot_in;
      if (rsp_load) begin
         rsp_pa_ff    <= rsp_pa_in;
         rsp_rd_ff    <= rsp_rd_in;
         rsp_large_ff <= rsp_large_in;
         rsp_fault_ff <= rsp_fault_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_rd_ff, rsp_pa_ff};
   assign rsp_tuser  = {rsp_fault_ff, rsp_large_ff};

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over an untaken result");

   a_wr_place: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == S_IDLE || state_ff == S_L2 || state_ff == S_L1))
      else $error("store written in the middle of a walk");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_fault_ff && rsp_large_ff))
      else $error("fault and large page both set");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != S_IDLE))
      else $error("accepted item left no work in flight");

endmodule

[bench/tb_four_level_page_table_walker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_four_level_page_table_walker: self-checking bench for the page walker
// Builds page tables through write items, then checks translate, enable-write
// and word reads against a walk predictor kept in step with the table store.
// Both stream sides idle at random; one long output hold-off backs up the
// request side. Walks only ever touch table words that were written first.
// ----------------------------------------------------------------------------
module tb_four_level_page_table_walker
   import pltw_pkg::*;
();

   localparam int STORE_LOG2  = 14;
   localparam int STORE_WORDS = 1 << STORE_LOG2;
   localparam int TABLE_PAGES = STORE_WORDS >> INDEX_BITS;   // 4 KB tables in the store
   localparam int PAGE_TOP    = STORE_LOG2 - INDEX_BITS + 11; // top in-store page bit
   localparam int IDLE_PCT    = 22;
   localparam int HOLD_CYCLES = 400;     // long output hold-off
   localparam int SETTLE      = 8;       // idle time before a root write
   localparam int DRAIN       = 12;

   typedef struct packed {
      logic [63:0] phys;
      logic [63:0] rdata;
      logic        is_2m;
      logic        fault;
   } walk_result_type;

   // Predicts each response from a shadow of the table store and root.
   class walk_scoreboard_type;
      bit [63:0]           table_words [STORE_WORDS];
      bit                  written [STORE_WORDS];
      bit [STORE_LOG2-1:0] page_words [TABLE_PAGES][$];   // written words, per 4 KB table
      bit [STORE_LOG2-1:0] written_list [$];
      bit [31:0]           root;
      walk_result_type     results_due [$];
      int unsigned         mismatches;

      function void store_word(bit [STORE_LOG2-1:0] w, bit [63:0] value);
         if (!written[w]) begin
            written[w] = 1'b1;
            page_words[w[STORE_LOG2-1:INDEX_BITS]].push_back(w);
            written_list.push_back(w);
         end
         table_words[w] = value;
      endfunction

      // Walks to the final entry; 0 on a table base outside the store.
      function bit walk(bit [47:0] va, output bit [STORE_LOG2-1:0] slot,
                        output bit is_2m);
         bit [63:0] base;
         base  = {32'b0, root};
         slot  = '0;
         is_2m = 1'b0;
         for (int lvl = 0; lvl < 4; lvl++) begin
            if (base[63:12] >= TABLE_PAGES) return 1'b0;
            slot = {base[PAGE_TOP:12], va[L1_LSB + INDEX_BITS*(3-lvl) +: INDEX_BITS]};
            if (lvl == 2 && table_words[slot][BIT_PS]) begin
               is_2m = 1'b1;
               return 1'b1;
            end
            base = table_words[slot];
         end
         return 1'b1;
      endfunction

      // Random VA whose walk reads only written words; a walk that leaves the
      // store stops there, so the bits below are left random.
      function bit pick_mapped_va(output bit [47:0] va);
         bit [63:0]                      base;
         bit [STORE_LOG2-INDEX_BITS-1:0] page;
         bit [STORE_LOG2-1:0]            w;
         int unsigned                    n;
         va[47:32] = 16'($urandom);
         va[31:0]  = $urandom;
         base = {32'b0, root};
         for (int lvl = 0; lvl < 4; lvl++) begin
            if (base[63:12] >= TABLE_PAGES) return 1'b1;
            page = base[PAGE_TOP:12];
            n = page_words[page].size();
            if (n == 0) return 1'b0;
            w = page_words[page][$urandom_range(n - 1)];
            va[L1_LSB + INDEX_BITS*(3-lvl) +: INDEX_BITS] = w[INDEX_BITS-1:0];
            if (lvl == 2 && table_words[w][BIT_PS]) return 1'b1;
            base = table_words[w];
         end
         return 1'b1;
      endfunction

      function void note(op_type op, bit [47:0] va, bit [13:0] widx, bit [63:0] data);
         walk_result_type     r;
         bit [STORE_LOG2-1:0] slot;
         bit                  is_2m;
         r = '0;
         case (op)
            OP_WRITE: store_word(widx, data);
            OP_READ:  r.rdata = table_words[widx];
            default: begin
               if (!walk(va, slot, is_2m)) begin
                  r.fault = 1'b1;
               end else begin
                  r.is_2m = is_2m;
                  if (op == OP_XLATE) begin
                     if (is_2m)
                        r.phys = (table_words[slot] & FRAME_2M) | ({16'b0, va} & OFFSET_2M);
                     else
                        r.phys = (table_words[slot] & FRAME_4K) | ({16'b0, va} & OFFSET_4K);
                  end else begin
                     store_word(slot, table_words[slot] | (64'd1 << BIT_RW));
                  end
               end
            end
         endcase
         results_due.push_back(r);
      endfunction

      function void report(string msg);
         mismatches++;
         $error("%s", msg);
      endfunction

      function void check(logic [127:0] tdata, logic [1:0] tuser);
         walk_result_type want;
         if (results_due.size() == 0) begin
            report($sformatf("response item with none pending: data %h user %b",
                             tdata, tuser));
            return;
         end
         want = results_due.pop_front();
         if (tdata[63:0] !== want.phys)
            report($sformatf("physical_address: expected %h, actual %h",
                             want.phys, tdata[63:0]));
         if (tdata[127:64] !== want.rdata)
            report($sformatf("read_data: expected %h, actual %h",
                             want.rdata, tdata[127:64]));
         if (tuser[0] !== want.is_2m)
            report($sformatf("large_page: expected %b, actual %b", want.is_2m, tuser[0]));
         if (tuser[1] !== want.fault)
            report($sformatf("fault: expected %b, actual %b", want.fault, tuser[1]));
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset;
   logic          csr_wr_en;
   logic [31:0]   csr_wr_data;    // root_table_address
   logic          req_tvalid;
   logic          req_tready;
   logic [127:0]  req_tdata;      // virtual_address[47:0], table_word_index[61:48],
                                  // write_data[125:62], zero[127:126]
   logic [1:0]    req_tuser;      // operation[1:0]
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [127:0]  rsp_tdata;      // physical_address[63:0], read_data[127:64]
   logic [1:0]    rsp_tuser;      // large_page[0], fault[1]

   walk_scoreboard_type sb = new();

   // steady_flow: no idling on either side; hold_output: one long hold-off
   bit          steady_flow;
   bit          hold_output;
   int unsigned accepted_items;

   four_level_page_table_walker #(
      .STORE_WORDS_LOG2 (STORE_LOG2)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit, far above the slowest legal run
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   // response side: random stalls, plus the long hold-off when asked
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_output) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_output = 1'b0;
         end else begin
            rsp_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // every accepted response item goes to the checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check(rsp_tdata, rsp_tuser);
   end

   // Offers one item (after random idle cycles) and notes it once accepted.
   task automatic offer_request(op_type op, bit [47:0] va, bit [13:0] widx,
                                bit [63:0] data);
      @(negedge clock);
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, data, widx, va};
      do @(posedge clock); while (!req_tready);
      sb.note(op, va, widx, data);
   endtask

   // Root is only written with the block drained and its walk finished.
   task automatic write_root(bit [31:0] value);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.results_due.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.root = value;
   endtask

   // One random item. Writes mostly carry table pointers into the store so
   // that later walks go deep; reads and walks only touch written words.
   task automatic random_request();
      bit [47:0]   va;
      bit [13:0]   widx;
      bit [63:0]   data;
      int unsigned roll, n;
      bit          ok;
      op_type      op;
      va[47:32] = 16'($urandom);
      va[31:0]  = $urandom;
      widx      = 14'($urandom);
      data      = {$urandom, $urandom};
      roll = $urandom_range(99);
      if (roll < 30)      op = OP_WRITE;
      else if (roll < 45) op = OP_READ;
      else if (roll < 80) op = OP_XLATE;
      else                op = OP_ENWR;

      if (op == OP_READ) begin
         n = sb.written_list.size();
         if (n == 0) op = OP_WRITE;
         else widx = sb.written_list[$urandom_range(n - 1)];
      end else if (op != OP_WRITE) begin
         ok = 1'b0;
         for (int t = 0; t < 8 && !ok; t++) ok = sb.pick_mapped_va(va);
         if (!ok) op = OP_WRITE;
      end

      if (op == OP_WRITE) begin
         roll = $urandom_range(99);
         if (roll < 55)       // clean pointer, page-size bit random
            data = {47'b0, 5'($urandom_range(TABLE_PAGES - 1)), 12'($urandom)};
         else if (roll < 75)  // pointer with attribute bits up top (NX etc.)
            data = {12'($urandom), 35'b0, 5'($urandom_range(TABLE_PAGES - 1)),
                    12'($urandom)};
      end
      offer_request(op, va, widx, data);
   endtask

   initial begin : stimulus
      bit [31:0] phase_root [6];
      int        phase_len [6];

      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_WRITE;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: root in table 1 with junk in its low 12 bits; L4 -> table 2,
      // L3 -> table 3, L2 -> table 4 or a 2 MB page, L1 frames in table 4.
      write_root(32'h0000_1ABC);
      offer_request(OP_WRITE, 48'h0, 14'h3FF, 64'h0000_0000_0000_2FFF);
      offer_request(OP_WRITE, 48'h0, 14'h400, 64'h0000_0000_0000_3007);
      offer_request(OP_WRITE, 48'h0, 14'h405, 64'h0000_0000_0002_0003); // first page past the store
      offer_request(OP_WRITE, 48'h0, 14'h406, 64'h8000_0000_0000_3003); // NX bit -> base outside
      offer_request(OP_WRITE, 48'h0, 14'h7FF, 64'h8000_0000_7FE0_0081); // 2 MB, RW clear
      offer_request(OP_WRITE, 48'h0, 14'h601, 64'h0000_0000_0000_4023);
      offer_request(OP_WRITE, 48'h0, 14'h602, 64'hFFFF_FFFF_FFFF_F000); // L1 base outside
      offer_request(OP_WRITE, 48'h0, 14'h9FF, 64'hFFFF_FFFF_FFFF_F000);
      offer_request(OP_WRITE, 48'h0, 14'h800, 64'h0);
      offer_request(OP_WRITE, 48'h0, 14'h3FFF, 64'hFFFF_FFFF_FFFF_FFFF);
      offer_request(OP_READ, 48'h0, 14'h3FFF, 64'h0);
      offer_request(OP_READ, 48'h0, 14'h800, 64'h0);
      // 2 MB mapping, 4 KB with all-ones frame and offset, 4 KB zero entry
      offer_request(OP_XLATE, {9'h1FF, 9'd0, 9'h1FF, 21'h1F_FFFF}, 14'h0, 64'h0);
      offer_request(OP_XLATE, {9'h1FF, 9'd0, 9'd1, 9'h1FF, 12'hFFF}, 14'h0, 64'h0);
      offer_request(OP_XLATE, {9'h1FF, 9'd0, 9'd1, 9'd0, 12'h000}, 14'h0, 64'h0);
      // table pointers outside the store at L3, L3 (high bit) and L2
      offer_request(OP_XLATE, {9'h1FF, 9'd5, 30'h3FFF_FFFF}, 14'h0, 64'h0);
      offer_request(OP_XLATE, {9'h1FF, 9'd6, 30'h0}, 14'h0, 64'h0);
      offer_request(OP_XLATE, {9'h1FF, 9'd0, 9'd2, 21'h15_5555}, 14'h0, 64'h0);
      // enable-write on the 2 MB and 4 KB entries, then read them back
      offer_request(OP_ENWR, {9'h1FF, 9'd0, 9'h1FF, 21'h0}, 14'h0, 64'h0);
      offer_request(OP_READ, 48'h0, 14'h7FF, 64'h0);
      offer_request(OP_ENWR, {9'h1FF, 9'd0, 9'd1, 9'd0, 12'h0}, 14'h0, 64'h0);
      offer_request(OP_READ, 48'h0, 14'h800, 64'h0);
      // faulting enable-write must leave the store alone
      offer_request(OP_ENWR, {9'h1FF, 9'd5, 30'h0}, 14'h0, 64'h0);
      offer_request(OP_READ, 48'h0, 14'h405, 64'h0);

      // Random phases, each with its own root: in-store tables (low bits
      // junk), all ones, last table page, zero, first page past the store.
      phase_root = '{{15'b0, 5'($urandom), 12'($urandom)}, 32'hFFFF_FFFF,
                     32'h0001_FFFF, 32'h0000_0000, 32'h0002_0000,
                     {15'b0, 5'($urandom), 12'($urandom)}};
      phase_len  = '{450, 80, 400, 400, 80, 440};
      for (int p = 0; p < 6; p++) begin
         write_root(phase_root[p]);
         for (int i = 0; i < phase_len[p]; i++) begin
            steady_flow = (accepted_items >= 900 && accepted_items < 1150);
            if (accepted_items == 300) hold_output = 1'b1;
            random_request();
            accepted_items++;
         end
      end
      steady_flow = 1'b0;

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.results_due.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      if (sb.mismatches == 0 && sb.results_due.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
